// ===== src/tilc_pkg.sv =====
package tilc_pkg;

  // Vertex coordinate width (two's complement).
  localparam int COORD_BITS = 16;
  // Edge delta: one bit wider than a coordinate.
  localparam int DELTA_W = COORD_BITS + 1;
  // One cross-product term, and the difference of two terms.
  localparam int PROD_W = 2 * DELTA_W;
  localparam int AREA_W = PROD_W + 1;
  // Sum of the gcds of the triangle's edges.
  localparam int BND_W = DELTA_W + 2;
  localparam int COUNT_W = 32;
  localparam int WIDE_W = (AREA_W > COUNT_W) ? AREA_W : COUNT_W;
  // gcd common power-of-two count.
  localparam int SHIFT_W = $clog2(DELTA_W + 1);

  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic [DELTA_W-1:0] mag_t;

  typedef struct packed {
    logic start;
    mag_t a;
    mag_t b;
  } gcd_req_t;

  typedef struct packed {
    logic done;
    mag_t value;
  } gcd_rsp_t;

  function automatic mag_t mag_of(delta_t d);
    mag_t m;
    m = d[DELTA_W-1] ? mag_t'(-d) : mag_t'(d);
    return m;
  endfunction

endpackage

// ===== src/tilc_gcd.sv =====
// Binary gcd, one reduction step per cycle. done pulses with the result.
module tilc_gcd (
  input  logic              clk,
  input  logic              rst,
  input  tilc_pkg::gcd_req_t req,
  output tilc_pkg::gcd_rsp_t rsp
);

  tilc_pkg::mag_t a;
  tilc_pkg::mag_t b;
  logic [tilc_pkg::SHIFT_W-1:0] k;
  logic busy;
  logic finish;

  assign finish = (a == '0) || (b == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (busy && finish) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
      k <= '0;
    end else if (busy && !finish) begin
      if (!a[0] && !b[0]) begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + 1'b1;
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a >= b) begin
        a <= (a - b) >> 1;
      end else begin
        b <= (b - a) >> 1;
      end
    end
  end

  assign rsp.done  = busy && finish;
  assign rsp.value = (a | b) << k;

endmodule

// ===== src/triangle_interior_lattice_count.sv =====
// Channel  | Signals                                | Beat
// ---------+----------------------------------------+-------------------------------
// item     | item_valid, item_ready, ax..cy         | one triangle, three vertices
// result   | result_valid, result_ready,            | one count of interior points
//          |   interior_count                       |
//
// Sequence: each triangle passes the two multiply states, the area state,
//   then one gcd run per edge and the final load. The binary gcd unit is
//   shared by the edges in turn.
// The one signed multiplier serves both cross-product terms in turn.
// Reset: rst is synchronous; it idles the sequencer and empties the result
//   register.
// Stalls: a held result does not block the next item; only the final load
//   into the result register waits for that register to free up.
module triangle_interior_lattice_count (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] ax,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] ay,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] bx,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] by,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] cx,
  input  logic signed [tilc_pkg::COORD_BITS-1:0] cy,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [tilc_pkg::COUNT_W-1:0]        interior_count
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL0   = 3'd1;  // ux * vy
  localparam logic [2:0] S_MUL1   = 3'd2;  // uy * vx
  localparam logic [2:0] S_AREA   = 3'd3;  // |difference| = twice the area
  localparam logic [2:0] S_GSTART = 3'd4;  // launch gcd on one edge
  localparam logic [2:0] S_GWAIT  = 3'd5;  // wait, accumulate boundary
  localparam logic [2:0] S_FINAL  = 3'd6;  // Pick's formula into result reg

  localparam logic [1:0] EDGE_U = 2'd0;
  localparam logic [1:0] EDGE_V = 2'd1;
  localparam logic [1:0] EDGE_W = 2'd2;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] edge_sel;

  // Edge vectors: u = b - a, v = c - a, w = c - b.
  tilc_pkg::delta_t ux, uy, vx, vy, wx, wy;

  logic signed [tilc_pkg::PROD_W-1:0] p0;
  logic signed [tilc_pkg::PROD_W-1:0] p1;
  logic signed [tilc_pkg::PROD_W-1:0] prod;
  tilc_pkg::delta_t mul_a;
  tilc_pkg::delta_t mul_b;

  logic signed [tilc_pkg::AREA_W-1:0] diff;
  logic [tilc_pkg::AREA_W-1:0] area2;
  logic [tilc_pkg::BND_W-1:0] bnd;

  tilc_pkg::gcd_req_t gcd_req;
  tilc_pkg::gcd_rsp_t gcd_rsp;

  logic [tilc_pkg::WIDE_W:0]   pick_sum;
  logic [tilc_pkg::WIDE_W-1:0] pick_half;
  logic [tilc_pkg::COUNT_W-1:0] count_next;
  logic item_take;
  logic out_free;

  assign item_ready = (state == S_IDLE);
  assign item_take  = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  // Shared multiplier, operands picked by the sequencer.
  assign mul_a = (state == S_MUL0) ? ux : uy;
  assign mul_b = (state == S_MUL0) ? vy : vx;
  assign prod  = tilc_pkg::PROD_W'(mul_a) * tilc_pkg::PROD_W'(mul_b);

  assign diff = tilc_pkg::AREA_W'(p0) - tilc_pkg::AREA_W'(p1);

  // gcd operands for the current edge
  always_comb begin
    gcd_req.start = (state == S_GSTART);
    case (edge_sel)
      EDGE_U: begin
        gcd_req.a = tilc_pkg::mag_of(ux);
        gcd_req.b = tilc_pkg::mag_of(uy);
      end
      EDGE_V: begin
        gcd_req.a = tilc_pkg::mag_of(vx);
        gcd_req.b = tilc_pkg::mag_of(vy);
      end
      default: begin
        gcd_req.a = tilc_pkg::mag_of(wx);
        gcd_req.b = tilc_pkg::mag_of(wy);
      end
    endcase
  end

  tilc_gcd u_gcd (
    .clk (clk),
    .rst (rst),
    .req (gcd_req),
    .rsp (gcd_rsp)
  );

  // Pick: I = (2A + 2 - B) / 2; 2A >= B - 2 for any proper triangle.
  always_comb begin
    pick_sum  = (tilc_pkg::WIDE_W+1)'(area2) + (tilc_pkg::WIDE_W+1)'(2)
              - (tilc_pkg::WIDE_W+1)'(bnd);
    pick_half = pick_sum[tilc_pkg::WIDE_W:1];
    if (area2 == '0) begin
      count_next = '0;  // collinear or coincident vertices
    end else if (pick_half > tilc_pkg::WIDE_W'({tilc_pkg::COUNT_W{1'b1}})) begin
      count_next = '1;
    end else begin
      count_next = pick_half[tilc_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (item_valid) state_next = S_MUL0;
      S_MUL0:   state_next = S_MUL1;
      S_MUL1:   state_next = S_AREA;
      S_AREA:   state_next = S_GSTART;
      S_GSTART: state_next = S_GWAIT;
      S_GWAIT: begin
        if (gcd_rsp.done) begin
          state_next = (edge_sel == EDGE_W) ? S_FINAL : S_GSTART;
        end
      end
      S_FINAL:  if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      edge_sel     <= EDGE_U;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (item_take) begin
        edge_sel <= EDGE_U;
      end else if (state == S_GWAIT && gcd_rsp.done && edge_sel != EDGE_W) begin
        edge_sel <= edge_sel + 1'b1;
      end
      if (state == S_FINAL && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (item_take) begin
      ux <= tilc_pkg::delta_t'(bx) - tilc_pkg::delta_t'(ax);
      uy <= tilc_pkg::delta_t'(by) - tilc_pkg::delta_t'(ay);
      vx <= tilc_pkg::delta_t'(cx) - tilc_pkg::delta_t'(ax);
      vy <= tilc_pkg::delta_t'(cy) - tilc_pkg::delta_t'(ay);
      wx <= tilc_pkg::delta_t'(cx) - tilc_pkg::delta_t'(bx);
      wy <= tilc_pkg::delta_t'(cy) - tilc_pkg::delta_t'(by);
      bnd <= '0;
    end
    if (state == S_MUL0) p0 <= prod;
    if (state == S_MUL1) p1 <= prod;
    if (state == S_AREA) begin
      area2 <= diff[tilc_pkg::AREA_W-1] ? tilc_pkg::AREA_W'(-diff) : tilc_pkg::AREA_W'(diff);
    end
    if (state == S_GWAIT && gcd_rsp.done) begin
      bnd <= bnd + tilc_pkg::BND_W'(gcd_rsp.value);
    end
    if (state == S_FINAL && out_free) begin
      interior_count <= count_next;
    end
  end

`ifndef SYNTH
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    item_take |=> state == S_MUL0)
    else $error("accepted item did not start the multiply");

  a_gcd_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    gcd_rsp.done |-> state == S_GWAIT)
    else $error("gcd finished outside the wait state");

  a_edge_range: assert property (@(posedge clk) disable iff (rst)
    edge_sel == EDGE_U || edge_sel == EDGE_V || edge_sel == EDGE_W)
    else $error("edge select out of range");

  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && out_free && area2 == '0) |=>
      result_valid && interior_count == '0)
    else $error("degenerate triangle gave nonzero count");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && out_free) |=> result_valid && state == S_IDLE)
    else $error("result load did not raise valid");
`endif

endmodule

// ===== test/triangle_interior_lattice_count_tb.sv =====
module triangle_interior_lattice_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [tilc_pkg::COORD_BITS-1:0] coord_t;
  typedef logic [tilc_pkg::COUNT_W-1:0] count_t;

  // One row of the directed table. Where 'typed' is set the count is known
  // by inspection; otherwise the row goes through the predictor.
  typedef struct {
    int     xa, ya, xb, yb, xc, yc;
    bit     typed;
    count_t count;
  } tri_row_t;

  localparam int N_ROWS = 19;

  // Directed triangles: degenerate shapes, tiny hand-checked triangles, the
  // corners of the coordinate range, both windings, and alternating bit
  // patterns so every coordinate bit toggles early.
  tri_row_t directed_rows [N_ROWS] = '{
    '{0, 0, 0, 0, 0, 0, 1'b1, 32'd0},                   // all zero: no end marker
    '{5, 7, 5, 7, 100, -3, 1'b1, 32'd0},                // two vertices coincide
    '{-32768, 32767, -32768, 32767, -32768, 32767, 1'b1, 32'd0},
    '{0, 0, 3, 6, -5, -10, 1'b1, 32'd0},                // collinear
    '{-32768, -32768, 0, 0, 32767, 32767, 1'b1, 32'd0}, // diagonal through range
    '{-32768, 32767, 32767, 32767, 0, 32767, 1'b1, 32'd0},
    '{0, 0, 1, 0, 0, 1, 1'b1, 32'd0},                   // unit triangle
    '{0, 0, 2, 0, 0, 2, 1'b1, 32'd0},
    '{0, 0, 3, 0, 0, 3, 1'b1, 32'd1},
    '{0, 0, 4, 0, 0, 4, 1'b1, 32'd3},
    '{-32768, -32768, 32767, -32768, -32768, 32767, 1'b0, 32'd0}, // largest area
    '{-32768, -32768, -32768, 32767, 32767, -32768, 1'b0, 32'd0}, // other winding
    '{32767, 32767, -32768, 32767, 32767, -32768, 1'b0, 32'd0},
    '{-32768, -32768, 32767, 32767, -32768, 32767, 1'b0, 32'd0},
    '{0, 0, 32767, 1, -32768, 0, 1'b0, 32'd0},          // sliver
    '{0, 0, 7, 3, 2, 9, 1'b0, 32'd0},                   // non-integer edge heights
    '{-1, -1, 1, -1, 0, 1, 1'b0, 32'd0},
    '{21845, -21846, -21846, 21845, 21845, 21845, 1'b0, 32'd0},
    '{-21846, 21845, 21845, -21846, -21846, -21846, 1'b0, 32'd0}
  };

  int corner_vals [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   item_valid = 1'b0;
  logic   item_ready;
  coord_t ax = '0, ay = '0, bx = '0, by = '0, cx = '0, cy = '0;
  logic   result_valid;
  logic   result_ready = 1'b0;
  count_t interior_count;

  // Expected interior counts, oldest first.
  count_t count_expected [$];
  count_t want_count;

  int send_idle_pct  = 0;   // chance per cycle that the sender holds back
  int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  int hold_request   = 0;   // set by the sequence, taken by the receiver
  int hold_left      = 0;
  int items_sent     = 0;
  int counts_checked = 0;
  int errors         = 0;

  triangle_interior_lattice_count u_dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .ax             (ax),
    .ay             (ay),
    .bx             (bx),
    .by             (by),
    .cx             (cx),
    .cy             (cy),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .interior_count (interior_count)
  );

  always #5 clk = ~clk;

  // Run ceiling: the slowest legal run (about 1300 triangles, plus sender
  // gaps and receiver stalls) is well under a fifth of this.
  initial begin
    #10_000_000;
    $display("timeout at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor: exact count by Pick's theorem.
  //   2A = |cross(b-a, c-a)|, B = sum of gcd(|dx|,|dy|) over the edges,
  //   interior = (2A - B + 2) / 2, zero for a degenerate triangle.
  // ---------------------------------------------------------------------
  function automatic longint unsigned span(longint d);
    return (d < 0) ? longint'(-d) : longint'(d);
  endfunction

  function automatic longint unsigned edge_gcd(longint unsigned p, longint unsigned q);
    longint unsigned r;
    while (q != 0) begin
      r = p % q;
      p = q;
      q = r;
    end
    return p;
  endfunction

  function automatic count_t interior_points(coord_t xa, ya, xb, yb, xc, yc);
    longint ux, uy, vx, vy, wx, wy, wedge;
    longint unsigned twice_area, boundary, interior;
    ux = longint'(xb) - longint'(xa);
    uy = longint'(yb) - longint'(ya);
    vx = longint'(xc) - longint'(xa);
    vy = longint'(yc) - longint'(ya);
    wx = longint'(xc) - longint'(xb);
    wy = longint'(yc) - longint'(yb);
    wedge = ux * vy - uy * vx;
    twice_area = span(wedge);
    if (twice_area == 0) return '0;
    boundary = edge_gcd(span(ux), span(uy)) + edge_gcd(span(vx), span(vy))
             + edge_gcd(span(wx), span(wy));
    interior = (twice_area + 2 - boundary) / 2;
    // only reachable with wider coordinates
    if (interior > 64'hFFFF_FFFF) interior = 64'hFFFF_FFFF;
    return count_t'(interior);
  endfunction

  // ---------------------------------------------------------------------
  // Item side. Valid is raised without looking at ready and held with a
  // steady payload until the beat is taken; the expectation is queued at
  // the accepting edge. Idle gaps are drawn per cycle from send_idle_pct.
  // ---------------------------------------------------------------------
  task automatic offer_triangle(input coord_t xa, ya, xb, yb, xc, yc,
                                input bit typed, input count_t typed_count);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    ax <= xa;
    ay <= ya;
    bx <= xb;
    by <= yb;
    cx <= xc;
    cy <= yc;
    do @(posedge clk); while (!item_ready);
    count_expected.push_back(typed ? typed_count
                                   : interior_points(xa, ya, xb, yb, xc, yc));
    items_sent++;
  endtask

  function automatic coord_t any_coord();
    return coord_t'($urandom());
  endfunction

  // Random triangles, mixed by shape so the gcd and area paths are all hit:
  // full-range vertices, small clustered ones, collinear sets, repeated
  // vertices, range corners, and lattice-scaled shapes with large edge gcds.
  task automatic send_random(input int n);
    coord_t v [6];
    int     pick, ox, oy, dx, dy, k1, k2, scale;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        foreach (v[j]) v[j] = any_coord();
      end else if (pick < 65) begin
        ox = $urandom_range(65535);
        oy = $urandom_range(65535);
        for (int j = 0; j < 3; j++) begin
          dx = $urandom_range(80);
          dy = $urandom_range(80);
          v[2*j]   = coord_t'(ox + dx - 40);
          v[2*j+1] = coord_t'(oy + dy - 40);
        end
      end else if (pick < 75) begin
        ox = $urandom_range(32000); ox -= 16000;
        oy = $urandom_range(32000); oy -= 16000;
        dx = $urandom_range(200);   dx -= 100;
        dy = $urandom_range(200);   dy -= 100;
        k1 = $urandom_range(200);   k1 -= 100;
        k2 = $urandom_range(200);   k2 -= 100;
        v = '{coord_t'(ox), coord_t'(oy), coord_t'(ox + k1 * dx),
              coord_t'(oy + k1 * dy), coord_t'(ox + k2 * dx), coord_t'(oy + k2 * dy)};
      end else if (pick < 82) begin
        foreach (v[j]) v[j] = any_coord();
        k1 = $urandom_range(2);
        k2 = (k1 + 1 + $urandom_range(1)) % 3;
        v[2*k2]   = v[2*k1];
        v[2*k2+1] = v[2*k1+1];
      end else if (pick < 90) begin
        foreach (v[j]) v[j] = coord_t'(corner_vals[$urandom_range(6)]);
      end else begin
        scale = 1 << $urandom_range(11);
        foreach (v[j]) begin
          k1 = $urandom_range(30);
          v[j] = coord_t'((k1 - 15) * scale);
        end
      end
      offer_triangle(v[0], v[1], v[2], v[3], v[4], v[5], 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side. Ready is drawn per cycle from recv_stall_pct, except
  // during a requested hold-off, which this process counts down itself.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each accepted result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (count_expected.size() == 0) begin
        $display("%0t: interior_count expected none, actual %0d", $time, interior_count);
        errors++;
      end else begin
        want_count = count_expected.pop_front();
        counts_checked++;
        if (interior_count !== want_count) begin
          $display("%0t: interior_count expected %0d, actual %0d",
                   $time, want_count, interior_count);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed table, then random triangles across the
  // idling phases, with one long result hold-off that backs the block up.
  // ---------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, no idling on either side
    for (int r = 0; r < N_ROWS; r++) begin
      offer_triangle(coord_t'(directed_rows[r].xa), coord_t'(directed_rows[r].ya),
                     coord_t'(directed_rows[r].xb), coord_t'(directed_rows[r].yb),
                     coord_t'(directed_rows[r].xc), coord_t'(directed_rows[r].yc),
                     directed_rows[r].typed, directed_rows[r].count);
    end

    send_random(300);

    send_idle_pct  = 75;
    recv_stall_pct = 0;
    send_random(300);

    send_idle_pct  = 0;
    recv_stall_pct = 75;
    send_random(300);

    // Back-pressure: result side shut for a long stretch while beats keep
    // coming, so the result register fills and item_ready must drop.
    recv_stall_pct = 0;
    hold_request   = 900;
    send_random(40);

    send_idle_pct  = 6;
    recv_stall_pct = 6;
    send_random(300);

    item_valid <= 1'b0;
    while (count_expected.size() != 0) @(posedge clk);
    // room for a stray late beat to show up
    repeat (150) @(posedge clk);
    if (count_expected.size() != 0) errors++;

    $display("covered %0d triangles: degenerate, extreme, collinear, scaled and random",
             items_sent);
    $display("%0d counts checked under free flow, sender gaps, receiver stalls, hold-off",
             counts_checked);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== triangle_interior_lattice_count.f =====
src/tilc_pkg.sv
src/tilc_gcd.sv
src/triangle_interior_lattice_count.sv
test/triangle_interior_lattice_count_tb.sv
